// File: design/cfca_pkg.sv
// Shared constants, types and helpers for the causal fault chain analyzer.
package cfca_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int CHAIN_MAX   = 16;
   localparam int NUM_RULES   = 6;
   localparam int REC_AW      = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int CH_AW       = $clog2(CHAIN_MAX);
   localparam int CHD_W       = $clog2(CHAIN_MAX + 1);
   localparam int RULE_AW     = $clog2(NUM_RULES);
   localparam int QDEPTH      = 4;
   localparam int Q_AW        = $clog2(QDEPTH);

   localparam logic [2:0] CSR_RULE_LAST  = 3'(NUM_RULES - 1);
   localparam logic [2:0] CSR_RULE_COUNT = 3'd6;
   localparam logic [2:0] CSR_FAULT_SEQ  = 3'd7;

   localparam logic [6:0] CAUSE_ANCHOR  = 7'd126;
   localparam logic [6:0] CAUSE_UNKNOWN = 7'd127;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOANCHOR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [7:0]  ev;
      logic [31:0] ts;
      logic [7:0]  actor;
   } rec_type;

   // job handed from front to back
   typedef struct packed {
      logic [1:0]      status;
      logic [REC_AW-1:0] anchor;
   } job_type;

   typedef struct packed {
      logic [REC_AW-1:0] pos;
      logic [6:0]        cause;
      logic [7:0]        conf;
   } node_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RULE, S_SCAN, S_BONUS, S_NEXT, S_ANCHOR,
      S_SUM, S_EMIT, S_ERR, S_WAIT
   } back_state_type;

   function automatic logic [7:0] cap_add(input logic [7:0] c, input logic [7:0] a);
      logic [8:0] s;
      s = {1'b0, c} + {1'b0, a};
      return (s > 9'd100) ? 8'd100 : s[7:0];
   endfunction

endpackage

// File: design/causal_fault_chain_analyzer.sv
// Causal fault chain analyzer: store, job queue and analysis engine.
// Usage:
//  - Records arrive on req_* and are taken at an edge with start high and
//    busy low; one record per cycle while loading.
//  - The record with req_last_record closes the bundle and queues a job;
//    busy stays high until the analysis engine has emitted its results.
//  - Results leave on rsp_* for one cycle each, marked by rsp_strobe;
//    rsp_last_node marks the final one. The receiver cannot stall.
//  - Analysis: the engine takes the job the cycle after the last record.
//    Each record is read (wait state), then each rule tried is checked
//    and may run a backward precursor scan; the rule that applies runs a
//    forward bonus scan; one store read per cycle. Then the anchor node is
//    added and the chain is totalled and emitted: a priming read, then
//    results back to back.
//  - An overflowed or anchorless bundle yields one status result, passing
//    through the job queue and the engine's error state.
//  - csr_* writes a rule word, the rule count or the fault sequence; write
//    only while idle.
//  - reset clears the bundle state and the csr registers; the record store is
//    not cleared and needs no clearing pass.
module causal_fault_chain_analyzer import cfca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_record_seq,
   input  logic [7:0]  req_event_code,
   input  logic [31:0] req_timestamp,
   input  logic [7:0]  req_actor,
   input  logic        req_last_record,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_node_record_index,
   output logic [6:0]  rsp_node_cause,
   output logic [7:0]  rsp_node_confidence,
   output logic [6:0]  rsp_verdict_cause,
   output logic [6:0]  rsp_total_confidence,
   output logic        rsp_chain_truncated,
   output logic        rsp_last_node
);
   logic [63:0]       rules_ff [NUM_RULES];
   logic [2:0]        count_ff;
   logic [31:0]       fseq_ff;
   logic              accept, wr_en, job_valid, q_ne, pop, back_busy, pend_ff;
   logic [REC_AW-1:0] wr_addr, rd_addr;
   rec_type           wr_data, rd_data_ff;
   rec_type           store [MAX_RECORDS];
   job_type           job, head;

   assign busy   = back_busy || q_ne || pend_ff;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_RULES; i++) rules_ff[i] <= '0;
         count_ff <= '0;
         fseq_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= accept && req_last_record;
         if (csr_write) begin
            if (csr_index <= CSR_RULE_LAST) rules_ff[csr_index[RULE_AW-1:0]] <= csr_data;
            else if (csr_index == CSR_RULE_COUNT) count_ff <= csr_data[2:0];
            else if (csr_index == CSR_FAULT_SEQ) fseq_ff <= csr_data[31:0];
         end
      end
      if (wr_en) store[wr_addr] <= wr_data;
      rd_data_ff <= store[rd_addr];
   end

   cfca_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .record_seq(req_record_seq), .event_code(req_event_code),
      .timestamp(req_timestamp), .actor(req_actor), .last_record(req_last_record),
      .fault_sequence(fseq_ff),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .job_valid(job_valid), .job(job)
   );

   cfca_queue u_queue (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job),
      .pop(pop), .not_empty(q_ne), .head(head)
   );

   cfca_back u_back (
      .clock(clock), .reset(reset), .job_valid(q_ne), .job(head), .job_pop(pop),
      .busy(back_busy), .rules(rules_ff), .rule_count(count_ff),
      .rd_addr(rd_addr), .rd_data(rd_data_ff),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_node_record_index(rsp_node_record_index),
      .rsp_node_cause(rsp_node_cause), .rsp_node_confidence(rsp_node_confidence),
      .rsp_verdict_cause(rsp_verdict_cause),
      .rsp_total_confidence(rsp_total_confidence),
      .rsp_chain_truncated(rsp_chain_truncated), .rsp_last_node(rsp_last_node)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_record |=> busy) else $error("busy not raised after last record");
   a_last_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_node |-> rsp_strobe) else $error("last node without strobe");
   a_conf_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_total_confidence <= 7'd100) else $error("total over cap");
endmodule

// File: design/cfca_front.sv
// Front end: stores records, tracks anchor and overflow, posts analysis jobs.
module cfca_front import cfca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [31:0]       record_seq,
   input  logic [7:0]        event_code,
   input  logic [31:0]       timestamp,
   input  logic [7:0]        actor,
   input  logic              last_record,
   input  logic [31:0]       fault_sequence,
   output logic              wr_en,
   output logic [REC_AW-1:0] wr_addr,
   output rec_type           wr_data,
   output logic              job_valid,
   output job_type           job
);
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [REC_AW-1:0] anchor_ff, anchor_in;
   logic              anchor_vld_ff, anchor_vld_in;
   logic              ovf_ff, ovf_in;
   logic              room, hit;

   assign room    = count_ff < CNT_W'(MAX_RECORDS);
   assign hit     = room && !anchor_vld_ff && (record_seq == fault_sequence);
   assign wr_en   = accept && room;
   assign wr_addr = count_ff[REC_AW-1:0];
   assign wr_data = '{ev: event_code, ts: timestamp, actor: actor};

   always_comb begin
      count_in      = count_ff;
      anchor_in     = anchor_ff;
      anchor_vld_in = anchor_vld_ff;
      ovf_in        = ovf_ff;
      job_valid     = 1'b0;
      job           = '{status: ST_OK, anchor: hit ? count_ff[REC_AW-1:0] : anchor_ff};
      if (accept) begin
         if (room) count_in = count_ff + 1'b1;
         if (hit) begin
            anchor_vld_in = 1'b1;
            anchor_in     = count_ff[REC_AW-1:0];
         end
         if (!room) ovf_in = 1'b1;
         if (last_record) begin
            job_valid = 1'b1;
            if (ovf_ff || !room) job.status = ST_OVERFLOW;
            else if (!(anchor_vld_ff || hit)) job.status = ST_NOANCHOR;
            count_in      = '0;
            anchor_vld_in = 1'b0;
            ovf_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         anchor_vld_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         count_ff      <= count_in;
         anchor_vld_ff <= anchor_vld_in;
         ovf_ff        <= ovf_in;
      end
      anchor_ff <= anchor_in;
   end
endmodule

// File: design/cfca_queue.sv
// Short job queue between the front end and the analysis engine.
module cfca_queue import cfca_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);
   job_type         mem_ff [QDEPTH];
   logic [Q_AW-1:0] wp_ff, rp_ff;
   logic [Q_AW:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

// File: design/cfca_back.sv
// Analysis engine: rule scan over the record store, chain build and emission.
module cfca_back import cfca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  job_type           job,
   output logic              job_pop,
   output logic              busy,
   input  logic [63:0]       rules [NUM_RULES],
   input  logic [2:0]        rule_count,
   output logic [REC_AW-1:0] rd_addr,
   input  rec_type           rd_data,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_node_record_index,
   output logic [6:0]        rsp_node_cause,
   output logic [7:0]        rsp_node_confidence,
   output logic [6:0]        rsp_verdict_cause,
   output logic [6:0]        rsp_total_confidence,
   output logic              rsp_chain_truncated,
   output logic              rsp_last_node
);
   back_state_type state_ff, state_in;
   job_type      job_ff, job_in;
   logic [REC_AW-1:0] r_ff, r_in, p_ff, p_in, found_ff, found_in;
   logic [RULE_AW-1:0] k_ff, k_in;
   rec_type      cur_ff, cur_in;
   logic [7:0]   conf_ff, conf_in;
   logic         bon_ff, bon_in;
   logic [CHD_W-1:0] depth_ff, depth_in, e_ff, e_in;
   logic         full_ff, full_in;
   logic [7:0]   best_ff, best_in;
   logic [6:0]   vc_ff, vc_in;
   logic [7:0]   tot_ff, tot_in;
   node_type     chain_ff [CHAIN_MAX];
   logic         ch_we;
   node_type     ch_wd;
   logic [CH_AW-1:0] ch_wa, ch_ra;
   node_type     ch_rd_ff;
   logic         ch_rd_vld_ff;
   logic [2:0]   nrules;
   rec_type      rd_q;

   // rule fields
   logic [63:0]  w;
   logic [7:0]   trig, prec, base;
   logic [31:0]  win, tick_gap;
   logic         same;
   logic [6:0]   cause;
   logic         in_win;

   assign nrules   = (rule_count > 3'(NUM_RULES)) ? 3'(NUM_RULES) : rule_count;
   assign w        = rules[k_ff];
   assign trig     = w[7:0];
   assign prec     = w[15:8];
   assign win      = w[47:16];
   assign same     = w[48];
   assign base     = w[56:49];
   assign cause    = w[63:57];
   assign rd_q     = rd_data;
   assign tick_gap = cur_ff.ts - rd_q.ts;
   assign in_win   = (win == '0) || (tick_gap <= win);
   assign busy     = state_ff != S_IDLE;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      r_in      = r_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      found_in  = found_ff;
      cur_in    = cur_ff;
      conf_in   = conf_ff;
      bon_in    = bon_ff;
      depth_in  = depth_ff;
      e_in      = e_ff;
      full_in   = full_ff;
      best_in   = best_ff;
      vc_in     = vc_ff;
      tot_in    = tot_ff;
      job_pop   = 1'b0;
      rd_addr   = r_ff;
      ch_we     = 1'b0;
      ch_wa     = depth_ff[CH_AW-1:0];
      ch_wd     = '{pos: r_ff, cause: cause, conf: conf_ff};
      ch_ra     = e_ff[CH_AW-1:0];
      rsp_strobe             = 1'b0;
      rsp_status             = ST_OK;
      rsp_node_record_index  = 6'(ch_rd_ff.pos);
      rsp_node_cause         = ch_rd_ff.cause;
      rsp_node_confidence    = ch_rd_ff.conf;
      rsp_verdict_cause      = vc_ff;
      rsp_total_confidence   = tot_ff[6:0];
      rsp_chain_truncated    = full_ff;
      rsp_last_node          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               r_in     = '0;
               depth_in = '0;
               full_in  = 1'b0;
               rd_addr  = '0;
               state_in = (job.status != ST_OK) ? S_ERR : S_WAIT;
            end
         end
         S_WAIT: begin
            // current record read returns this cycle
            cur_in   = rd_q;
            k_in     = '0;
            state_in = (nrules == '0) ? S_NEXT : S_RULE;
         end
         S_RULE: begin
            if (cur_ff.ev == trig && r_ff != '0) begin
               p_in     = r_ff - 1'b1;
               rd_addr  = r_ff - 1'b1;
               state_in = S_SCAN;
            end else if (32'(k_ff) + 1 >= 32'(nrules)) begin
               state_in = S_NEXT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_SCAN: begin
            // rd_q holds record p
            if ((rd_q.ev == prec && (!in_win || !same || rd_q.actor == cur_ff.actor))
                || p_ff == '0) begin
               if (rd_q.ev == prec && in_win && (!same || rd_q.actor == cur_ff.actor)) begin
                  found_in = p_ff;
                  conf_in  = same ? cap_add(base, 8'd10) : base;
                  bon_in   = 1'b0;
                  p_in     = '0;
                  rd_addr  = '0;
                  state_in = S_BONUS;
               end else if (32'(k_ff) + 1 >= 32'(nrules)) begin
                  state_in = S_NEXT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_RULE;
               end
            end else begin
               p_in    = p_ff - 1'b1;
               rd_addr = p_ff - 1'b1;
            end
         end
         S_BONUS: begin
            // rd_q holds record p, forward from 0 up to r-1
            if (!bon_ff && p_ff != found_ff && rd_q.ev == prec && in_win) begin
               bon_in = 1'b1;
            end
            if (p_ff + 1'b1 == r_ff || (!bon_ff && p_ff != found_ff && rd_q.ev == prec
                && in_win)) begin
               if (32'(depth_ff) < CHAIN_MAX) begin
                  ch_we    = 1'b1;
                  ch_wd.conf = (bon_ff || (p_ff != found_ff && rd_q.ev == prec && in_win))
                               ? cap_add(conf_ff, 8'd5) : conf_ff;
                  depth_in = depth_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
               state_in = S_NEXT;
            end else begin
               p_in    = p_ff + 1'b1;
               rd_addr = p_ff + 1'b1;
            end
         end
         S_NEXT: begin
            if (r_ff == job_ff.anchor) begin
               state_in = S_ANCHOR;
            end else begin
               r_in      = r_ff + 1'b1;
               rd_addr   = r_ff + 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_ANCHOR: begin
            ch_ra = CH_AW'(depth_ff - 1'b1);
            if (depth_ff == '0 || !ch_rd_vld_ff || ch_rd_ff.pos != job_ff.anchor) begin
               if (depth_ff == '0 || ch_rd_vld_ff) begin
                  if (32'(depth_ff) < CHAIN_MAX) begin
                     ch_we    = 1'b1;
                     ch_wd    = '{pos: job_ff.anchor, cause: CAUSE_ANCHOR, conf: 8'd0};
                     depth_in = depth_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
            end
            if (depth_ff == '0 || ch_rd_vld_ff) begin
               e_in     = '0;
               best_in  = '0;
               vc_in    = CAUSE_UNKNOWN;
               tot_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            // ch_rd_ff holds node e-1 once e > 0
            if (ch_rd_vld_ff && e_ff != '0) begin
               if (ch_rd_ff.conf > best_ff) begin
                  best_in = ch_rd_ff.conf;
                  vc_in   = ch_rd_ff.cause;
               end
               tot_in = cap_add(tot_ff, ch_rd_ff.conf);
            end
            if (e_ff == depth_ff) begin
               e_in     = '0;
               state_in = S_EMIT;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_EMIT: begin
            // first cycle primes the chain read, then one node per cycle
            if (ch_rd_vld_ff && e_ff != '0) begin
               rsp_strobe    = 1'b1;
               rsp_last_node = e_ff == depth_ff;
               if (e_ff == depth_ff) state_in = S_IDLE;
               else e_in = e_ff + 1'b1;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_ERR: begin
            rsp_strobe             = 1'b1;
            rsp_status             = job_ff.status;
            rsp_node_record_index  = '0;
            rsp_node_cause         = CAUSE_UNKNOWN;
            rsp_node_confidence    = '0;
            rsp_verdict_cause      = CAUSE_UNKNOWN;
            rsp_total_confidence   = '0;
            rsp_chain_truncated    = 1'b0;
            rsp_last_node          = 1'b1;
            state_in               = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // chain read address lags by one: read e-1 during sum/emit
   logic [CH_AW-1:0] ch_ra_eff;
   always_comb begin
      ch_ra_eff = ch_ra;
      if (state_in == S_SUM || state_in == S_EMIT) ch_ra_eff = CH_AW'(e_in - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_rd_vld_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_rd_vld_ff <= (state_in == state_ff) && !ch_we;
      end
      job_ff    <= job_in;
      r_ff      <= r_in;
      p_ff      <= p_in;
      k_ff      <= k_in;
      found_ff  <= found_in;
      cur_ff    <= cur_in;
      conf_ff   <= conf_in;
      bon_ff    <= bon_in;
      depth_ff  <= depth_in;
      e_ff      <= e_in;
      full_ff   <= full_in;
      best_ff   <= best_in;
      vc_ff     <= vc_in;
      tot_ff    <= tot_in;
      if (ch_we) chain_ff[ch_wa] <= ch_wd;
      ch_rd_ff  <= chain_ff[ch_ra_eff];
   end
endmodule
